/* hw/rtl/integer_to_radix_text_top_assert.svh */
// Assertion macros for the integer to radix text converter.
`ifndef INTEGER_TO_RADIX_TEXT_TOP_ASSERT_SVH
`define INTEGER_TO_RADIX_TEXT_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ITRT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ITRT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* hw/rtl/itrt_pkg.sv */
// Package with the shared constants, types and helpers of the radix text converter.
package itrt_pkg;

  localparam int VALUE_BITS_DEF = 32;
  localparam int BASE_W         = 5;
  localparam int WIDTH_W        = 7;
  localparam int CHAR_W         = 7;
  localparam int MAX_CHARS      = 64;
  localparam int QUEUE_DEPTH    = 2;

  localparam logic [BASE_W-1:0]  BASE_MIN    = 5'd2;
  localparam logic [BASE_W-1:0]  BASE_LIMIT  = 5'd25;
  localparam logic [BASE_W-1:0]  DIGIT_LIMIT = 5'd10;
  localparam logic [WIDTH_W-1:0] WIDTH_MAX   = 7'd64;

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
  localparam logic [CHAR_W-1:0] CHAR_NINE  = 7'h39;
  localparam logic [CHAR_W-1:0] CHAR_A     = 7'h41;
  localparam logic [CHAR_W-1:0] CHAR_N     = 7'h4E;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2D;
  localparam logic [CHAR_W-1:0] CHAR_SPACE = 7'h20;

  typedef struct packed {
    logic               neg;
    logic [BASE_W-1:0]  base;
    logic [WIDTH_W-1:0] width;
  } itrt_meta_t;

  localparam int META_W = $bits(itrt_meta_t);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_EMIT
  } back_state_t;

  function automatic logic [CHAR_W-1:0] glyph(input logic [BASE_W-1:0] d);
    if (d < DIGIT_LIMIT) begin
      return CHAR_ZERO + CHAR_W'(d);
    end
    return CHAR_A + CHAR_W'(d - DIGIT_LIMIT);
  endfunction

endpackage

/* hw/rtl/itrt_if.sv */
// Handshake interfaces for the input items and the result characters.
interface itrt_in_if import itrt_pkg::*; #(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) ();
  logic                         valid;
  logic                         ready;
  logic signed [VALUE_BITS-1:0] value;
  logic [BASE_W-1:0]            base;
  logic [WIDTH_W-1:0]           min_width;

  modport source (output valid, output value, output base, output min_width, input ready);
  modport sink (input valid, input value, input base, input min_width, output ready);
endinterface

interface itrt_out_if import itrt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_out;
  logic              last;

  modport source (output valid, output char_out, output last, input ready);
  modport sink (input valid, input char_out, input last, output ready);
endinterface

/* hw/rtl/itrt_queue.sv */
// Short queue of classified items between the front and the back of the converter.
module itrt_queue import itrt_pkg::*; #(
  parameter int DATA_W = VALUE_BITS_DEF + META_W
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [DATA_W-1:0] wdata,
  input  logic              pop,
  output logic [DATA_W-1:0] rdata,
  output logic              empty,
  output logic              full
);
  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [DATA_W-1:0] slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    cnt_nxt = cnt_r + CNT_W'(push) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= wdata;
    end
  end

  assign rdata = slot_r[rd_ptr_r];
  assign empty = (cnt_r == '0);
  assign full  = (cnt_r == CNT_W'(QUEUE_DEPTH));
endmodule

/* hw/rtl/itrt_front.sv */
// Front end: accepts items, clamps base and width, and splits sign from magnitude.
module itrt_front import itrt_pkg::*; #(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  itrt_in_if.sink                           in_ch,
  input  logic                              q_full,
  output logic                              q_push,
  output logic [VALUE_BITS+META_W-1:0]      q_wdata
);
  logic [VALUE_BITS-1:0] value;
  logic [VALUE_BITS-1:0] mag;
  itrt_meta_t            meta;

  always_comb begin
    value     = VALUE_BITS'(in_ch.value);
    meta.neg  = value[VALUE_BITS-1];
    mag       = meta.neg ? (~value + 1'b1) : value;
    if (in_ch.base < BASE_MIN) begin
      meta.base = BASE_MIN;
    end else if (in_ch.base > BASE_LIMIT - 1'b1) begin
      meta.base = BASE_LIMIT - 1'b1;
    end else begin
      meta.base = in_ch.base;
    end
    meta.width = (in_ch.min_width > WIDTH_MAX) ? WIDTH_MAX : in_ch.min_width;
  end

  assign in_ch.ready = !q_full;
  assign q_push      = in_ch.valid && !q_full;
  assign q_wdata     = {mag, meta};
endmodule

/* hw/rtl/itrt_back.sv */
// Back end: bit-serial digit divider, digit stack and character output register.
module itrt_back import itrt_pkg::*; #(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         q_empty,
  input  logic [VALUE_BITS+META_W-1:0] q_rdata,
  output logic                         q_pop,
  itrt_out_if.source                   out_ch
);
  localparam int STEP_W = $clog2(VALUE_BITS);
  localparam int ND_W   = $clog2(VALUE_BITS + 2);
  localparam int SUM_W  = WIDTH_W + 1;

  back_state_t           state_r, state_nxt;
  logic [VALUE_BITS-1:0] mag_r, mag_nxt;
  logic [BASE_W-1:0]     rem_r, rem_nxt;
  logic [STEP_W-1:0]     step_r, step_nxt;
  logic [BASE_W-1:0]     base_r, base_nxt;
  logic [WIDTH_W-1:0]    width_r, width_nxt;
  logic                  neg_r, neg_nxt;
  logic [ND_W-1:0]       nd_r, nd_nxt;
  logic [BASE_W-1:0]     stack_r [VALUE_BITS];
  logic [BASE_W-1:0]     stack_nxt [VALUE_BITS];
  logic [WIDTH_W-1:0]    pad_r, pad_nxt;
  logic                  sign_r, sign_nxt;
  logic [ND_W-1:0]       dig_r, dig_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0]     out_char_r, out_char_nxt;
  logic                  out_last_r, out_last_nxt;

  itrt_meta_t            q_meta;
  logic [VALUE_BITS-1:0] q_mag;
  logic [BASE_W:0]       trial;
  logic                  ge;
  logic [BASE_W-1:0]     rem_step;
  logic [VALUE_BITS-1:0] mag_step;
  logic [SUM_W-1:0]      body;
  logic                  slot_free;
  logic                  fin_last;

  assign q_meta = q_rdata[META_W-1:0];
  assign q_mag  = q_rdata[VALUE_BITS+META_W-1:META_W];

  always_comb begin
    trial    = {rem_r, mag_r[VALUE_BITS-1]};
    ge       = (trial >= {1'b0, base_r});
    rem_step = ge ? BASE_W'(trial - {1'b0, base_r}) : BASE_W'(trial);
    mag_step = {mag_r[VALUE_BITS-2:0], ge};
  end

  always_comb begin
    state_nxt     = state_r;
    mag_nxt       = mag_r;
    rem_nxt       = rem_r;
    step_nxt      = step_r;
    base_nxt      = base_r;
    width_nxt     = width_r;
    neg_nxt       = neg_r;
    nd_nxt        = nd_r;
    stack_nxt     = stack_r;
    pad_nxt       = pad_r;
    sign_nxt      = sign_r;
    dig_nxt       = dig_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    q_pop         = 1'b0;
    body          = '0;
    fin_last      = 1'b0;
    slot_free     = !out_valid_r || out_ch.ready;

    unique case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          mag_nxt   = q_mag;
          base_nxt  = q_meta.base;
          width_nxt = q_meta.width;
          neg_nxt   = q_meta.neg;
          rem_nxt   = '0;
          step_nxt  = '0;
          nd_nxt    = '0;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        mag_nxt  = mag_step;
        rem_nxt  = rem_step;
        step_nxt = step_r + 1'b1;
        if (step_r == STEP_W'(VALUE_BITS - 1)) begin
          stack_nxt[0] = rem_step;
          for (int k = 1; k < VALUE_BITS; k++) begin
            stack_nxt[k] = stack_r[k-1];
          end
          nd_nxt   = nd_r + 1'b1;
          rem_nxt  = '0;
          step_nxt = '0;
          if (mag_step == '0) begin
            body      = SUM_W'(nd_nxt) + SUM_W'(neg_r);
            pad_nxt   = (SUM_W'(width_r) > body) ? WIDTH_W'(SUM_W'(width_r) - body) : '0;
            sign_nxt  = neg_r && (body <= SUM_W'(MAX_CHARS));
            dig_nxt   = nd_nxt;
            state_nxt = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          if (pad_r != '0) begin
            out_char_nxt = CHAR_SPACE;
            out_last_nxt = 1'b0;
            pad_nxt      = pad_r - 1'b1;
          end else if (sign_r) begin
            out_char_nxt = CHAR_MINUS;
            out_last_nxt = 1'b0;
            sign_nxt     = 1'b0;
          end else begin
            out_char_nxt = glyph(stack_r[0]);
            fin_last     = (dig_r == ND_W'(1));
            out_last_nxt = fin_last;
            dig_nxt      = dig_r - 1'b1;
            for (int k = 0; k < VALUE_BITS - 1; k++) begin
              stack_nxt[k] = stack_r[k+1];
            end
            if (fin_last) begin
              state_nxt = ST_IDLE;
            end
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mag_r      <= mag_nxt;
    rem_r      <= rem_nxt;
    step_r     <= step_nxt;
    base_r     <= base_nxt;
    width_r    <= width_nxt;
    neg_r      <= neg_nxt;
    nd_r       <= nd_nxt;
    stack_r    <= stack_nxt;
    pad_r      <= pad_nxt;
    sign_r     <= sign_nxt;
    dig_r      <= dig_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.char_out = out_char_r;
  assign out_ch.last     = out_last_r;
endmodule

/* hw/rtl/integer_to_radix_text_top.sv */
// Integer to radix text converter: signed value in, ASCII characters out, one item each.
// Each input item is classified on entry and waits in a two-entry queue, so up to two
// further items are taken while one is being converted. A bit-serial restoring divider
// produces the digits of each number one at a time into a digit stack.
// Characters leave through a registered output that keeps the last one while the
// consumer stalls, and the final character of each number has last set.
`include "integer_to_radix_text_top_assert.svh"

module integer_to_radix_text_top import itrt_pkg::*; #(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  itrt_in_if.sink    in_ch,
  itrt_out_if.source out_ch
);
  localparam int DATA_W = VALUE_BITS + META_W;

  logic              q_push;
  logic              q_pop;
  logic              q_empty;
  logic              q_full;
  logic [DATA_W-1:0] q_wdata;
  logic [DATA_W-1:0] q_rdata;

  itrt_front #(.VALUE_BITS(VALUE_BITS)) u_front (
    .in_ch   (in_ch),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_wdata (q_wdata)
  );

  itrt_queue #(.DATA_W(DATA_W)) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty),
    .full  (q_full)
  );

  itrt_back #(.VALUE_BITS(VALUE_BITS)) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .q_rdata (q_rdata),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

  `ITRT_ASSERT_NOW(a_pop_needs_item, q_pop, !q_empty, "Back end took an item from an empty queue.")
  `ITRT_ASSERT_NOW(a_last_is_digit, out_ch.valid && out_ch.last, (out_ch.char_out >= CHAR_ZERO && out_ch.char_out <= CHAR_NINE) || (out_ch.char_out >= CHAR_A && out_ch.char_out <= CHAR_N), "The final character of a number is not a digit.")
  `ITRT_ASSERT_NEXT(a_text_unbroken, out_ch.valid && out_ch.ready && !out_ch.last, out_ch.valid, "Characters of one number did not follow without a gap.")
endmodule

/* bench/integer_to_radix_text_top_tb.sv */
// Testbench for the integer to radix text converter with its own text predictor.
`timescale 1ns / 1ps

module integer_to_radix_text_top_tb import itrt_pkg::*; ();

  typedef struct packed {
    logic [31:0]        value;
    logic [BASE_W-1:0]  base;
    logic [WIDTH_W-1:0] min_width;
  } number_req_t;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
  } text_char_t;

  logic clk;
  logic rst_n;

  itrt_in_if  in_ch ();
  itrt_out_if out_ch ();

  integer_to_radix_text_top u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  number_req_t pending_numbers[$];
  text_char_t  expected_text[$];
  int unsigned mismatch_count = 0;
  int unsigned send_idle_pct = 14;
  int unsigned recv_idle_pct = 61;

  initial begin
    clk             = 1'b0;
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.value     = '0;
    in_ch.base      = '0;
    in_ch.min_width = '0;
    out_ch.ready    = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    if (mismatch_count < 40) begin
      $display("[%0t] mismatch: %s", $realtime, msg);
    end
    mismatch_count++;
  endtask

  function automatic logic [CHAR_W-1:0] digit_char(input logic [BASE_W-1:0] d);
    if (d < DIGIT_LIMIT) begin
      return CHAR_ZERO + CHAR_W'(d);
    end
    return CHAR_A + CHAR_W'(d - DIGIT_LIMIT);
  endfunction

  function automatic void predict_text(input logic [31:0] value, input logic [BASE_W-1:0] base,
                                       input logic [WIDTH_W-1:0] min_width);
    logic              neg;
    logic [31:0]       mag;
    int unsigned       radix;
    int unsigned       width;
    int unsigned       body;
    int unsigned       total;
    int unsigned       i;
    logic [BASE_W-1:0] digits[$];
    logic [CHAR_W-1:0] chars[$];
    neg   = value[31];
    mag   = neg ? -value : value;
    radix = base;
    width = min_width;
    if (radix < BASE_MIN) begin
      radix = BASE_MIN;
    end
    if (radix > BASE_LIMIT - 1) begin
      radix = BASE_LIMIT - 1;
    end
    if (width > WIDTH_MAX) begin
      width = WIDTH_MAX;
    end
    do begin
      digits.push_front(BASE_W'(mag % radix));
      mag = mag / radix;
    end while (mag != 0);
    body  = digits.size() + (neg ? 1 : 0);
    total = (body < width) ? width : body;
    for (i = body; i < total; i++) begin
      chars.push_back(CHAR_SPACE);
    end
    if (neg) begin
      chars.push_back(CHAR_MINUS);
    end
    foreach (digits[k]) begin
      chars.push_back(digit_char(digits[k]));
    end
    foreach (chars[k]) begin
      expected_text.push_back('{ch: chars[k], last: (k == chars.size() - 1)});
    end
  endfunction

  function automatic logic [31:0] random_value();
    logic [31:0] v;
    case ($urandom_range(5))
      0: v = $urandom();
      1: v = $urandom_range(60);
      2: v = -$urandom_range(60);
      3: begin
        case ($urandom_range(4))
          0: v = 32'h8000_0000;
          1: v = 32'h7fff_ffff;
          2: v = 32'hffff_ffff;
          3: v = 32'h0000_0001;
          default: v = 32'h0;
        endcase
      end
      default: begin
        v = $urandom() >> $urandom_range(31);
        if ($urandom_range(1)) begin
          v = -v;
        end
      end
    endcase
    return v;
  endfunction

  task automatic queue_number(input logic [31:0] value, input int unsigned base,
                              input int unsigned min_width);
    pending_numbers.push_back('{value: value, base: BASE_W'(base),
                                min_width: WIDTH_W'(min_width)});
  endtask

  task automatic queue_random(input int unsigned count);
    int unsigned b;
    int unsigned w;
    repeat (count) begin
      b = ($urandom_range(9) == 0) ? $urandom_range(31) : $urandom_range(24, 2);
      w = ($urandom_range(9) < 2) ? $urandom_range(127) : $urandom_range(16);
      queue_number(random_value(), b, w);
    end
  endtask

  task automatic wait_drained();
    while (pending_numbers.size() != 0 || expected_text.size() != 0) begin
      @(posedge clk);
    end
  endtask

  always @(posedge clk) begin : drive_numbers
    number_req_t req;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (pending_numbers.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        req = pending_numbers.pop_front();
        in_ch.value     <= req.value;
        in_ch.base      <= req.base;
        in_ch.min_width <= req.min_width;
        in_ch.valid     <= 1'b1;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin : check_text
    text_char_t want;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_text.size() == 0) begin
          report_mismatch($sformatf("unexpected char 0x%02h last %0b",
                                    out_ch.char_out, out_ch.last));
        end else begin
          want = expected_text.pop_front();
          if (out_ch.char_out !== want.ch) begin
            report_mismatch($sformatf("char_out 0x%02h, expected 0x%02h",
                                      out_ch.char_out, want.ch));
          end
          if (out_ch.last !== want.last) begin
            report_mismatch($sformatf("last %0b, expected %0b on char 0x%02h",
                                      out_ch.last, want.last, want.ch));
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        predict_text(in_ch.value, in_ch.base, in_ch.min_width);
      end
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    queue_number(32'h0000_0000, 10, 0);
    queue_number(32'h7fff_ffff, 10, 0);
    queue_number(32'h8000_0000, 10, 0);
    queue_number(32'h8000_0000, 2, 0);
    queue_number(32'hffff_ffff, 2, 0);
    queue_number(32'h7fff_ffff, 2, 64);
    queue_number(32'hffff_ffff, 16, 127);
    queue_number(32'd12345, 0, 0);
    queue_number(32'd12345, 1, 0);
    queue_number(32'd12345, 25, 0);
    queue_number(32'd12345, 31, 0);
    queue_number(32'd23, 24, 0);
    queue_number(32'h7fff_ffff, 24, 0);
    queue_number(32'h8000_0001, 24, 5);
    queue_number(32'd255, 16, 65);
    queue_number(-32'sd42, 10, 3);
    queue_number(-32'sd42, 10, 4);
    queue_number(-32'sd42, 10, 10);
    queue_number(32'd1, 3, 0);
    queue_number(32'd0, 2, 64);
    queue_number(-32'sd5, 7, 1);
    queue_number(32'h5555_5555, 13, 0);
    queue_number(32'haaaa_aaaa, 20, 30);
    queue_random(29);
    wait_drained();

    @(negedge clk);
    send_idle_pct = 61;
    recv_idle_pct = 14;
    queue_random(29);
    wait_drained();

    @(negedge clk);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_random(29);
    wait_drained();

    repeat (1200) @(posedge clk);
    if (in_ch.valid) begin
      report_mismatch("an item was never accepted");
    end
    if (expected_text.size() != 0) begin
      report_mismatch($sformatf("%0d characters never arrived", expected_text.size()));
    end
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
